[sv/rgbyh_pkg.sv]
// ----------------------------------------------------------------------------
// rgbyh_pkg
// Shared constants and types for the RGB to YUV converter with luma histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbyh_pkg;

  localparam int HIST_BINS  = 256;
  localparam int BIN_BITS   = $clog2(HIST_BINS);
  localparam int COUNT_BITS = 24;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [23:0] W_YR = 24'd19595;
  localparam logic [23:0] W_YG = 24'd38470;
  localparam logic [23:0] W_YB = 24'd7471;

  localparam logic [24:0] W_UR = 25'd11058;
  localparam logic [24:0] W_UG = 25'd21710;
  localparam logic [24:0] W_UB = 25'd32768;
  localparam logic [24:0] W_VR = 25'd32768;
  localparam logic [24:0] W_VG = 25'd27439;
  localparam logic [24:0] W_VB = 25'd5329;

  localparam logic [24:0] CHROMA_OFS = 25'd8388608;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic                rd_en;
    logic [BIN_BITS-1:0] rd_bin;
    logic                wr_en;
    logic [BIN_BITS-1:0] wr_bin;
    logic                wr_clear;
  } hist_req_t;

endpackage

`default_nettype wire

[sv/rgb_to_yuv_with_luma_histogram.sv]
// ----------------------------------------------------------------------------
// rgb_to_yuv_with_luma_histogram
// BT.601 RGB to YUV converter that counts every pixel in a 256-bin luma
// histogram and reads and clears bins on request.
// ----------------------------------------------------------------------------
// Input beats arrive on in_valid / in_stall; a beat with cmd clear carries a
// pixel, a beat with cmd set reads and clears the bin named by bin_index.
// Each input beat produces exactly one output beat on out_valid / out_stall,
// in order. A pixel beat returns luma, chroma_u and chroma_v with bin_count
// zero; a bin beat returns the bin's count with the other fields zero.
// Each beat passes through stage a, stage b and the output register, and
// one beat is taken every cycle while the receiver does not stall. The
// histogram update is a read-modify-write over one read port and one write
// port with a bypass, so hits on the same bin in consecutive beats still
// count at full rate.
// Reset empties the pipeline and marks all bins as zero in the same cycle.
// When the receiver stalls, the output beat holds and the pipeline fills;
// in_stall rises once both internal stages and the output register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_yuv_with_luma_histogram
  import rgbyh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire logic            [7:0] chan_r,
  input  wire logic            [7:0] chan_g,
  input  wire logic            [7:0] chan_b,
  input  wire logic            [7:0] bin_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                 [7:0] luma,
  output logic                 [7:0] chroma_u,
  output logic                 [7:0] chroma_v,
  output logic      [COUNT_BITS-1:0] bin_count
);

  logic                  a_valid;
  logic                  a_cmd;
  logic [7:0]            a_r;
  logic [7:0]            a_g;
  logic [7:0]            a_b;
  logic [BIN_BITS-1:0]   a_idx;
  logic [7:0]            a_y;
  logic [7:0]            a_u;
  logic [7:0]            a_v;

  logic                  b_valid;
  logic                  b_cmd;
  logic [BIN_BITS-1:0]   b_bin;
  logic [7:0]            b_y;
  logic [7:0]            b_u;
  logic [7:0]            b_v;

  logic                  fire_b;
  logic                  adv_a;
  logic [BIN_BITS-1:0]   a_bin;
  logic [COUNT_BITS-1:0] old_cnt;
  hist_req_t             req;

  rgbyh_conv u_conv (
    .chan_r (a_r),
    .chan_g (a_g),
    .chan_b (a_b),
    .y      (a_y),
    .u      (a_u),
    .v      (a_v)
  );

  always_comb begin
    fire_b       = b_valid && (!out_valid || !out_stall);
    adv_a        = a_valid && (!b_valid || fire_b);
    in_stall     = a_valid && !adv_a;
    a_bin        = (a_cmd == CMD_READ) ? a_idx : BIN_BITS'(a_y);
    req.rd_en    = adv_a;
    req.rd_bin   = a_bin;
    req.wr_en    = fire_b;
    req.wr_bin   = b_bin;
    req.wr_clear = (b_cmd == CMD_READ);
  end

  rgbyh_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .old_cnt (old_cnt)
  );

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_cmd <= cmd;
      a_r   <= chan_r;
      a_g   <= chan_g;
      a_b   <= chan_b;
      a_idx <= BIN_BITS'(bin_index);
    end
    if (adv_a) begin
      b_cmd <= a_cmd;
      b_bin <= a_bin;
      b_y   <= a_y;
      b_u   <= a_u;
      b_v   <= a_v;
    end
    if (fire_b) begin
      if (b_cmd == CMD_READ) begin
        luma      <= '0;
        chroma_u  <= '0;
        chroma_v  <= '0;
        bin_count <= old_cnt;
      end else begin
        luma      <= b_y;
        chroma_u  <= b_u;
        chroma_v  <= b_v;
        bin_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        a_valid <= 1'b1;
      end else if (adv_a) begin
        a_valid <= 1'b0;
      end
      if (adv_a) begin
        b_valid <= 1'b1;
      end else if (fire_b) begin
        b_valid <= 1'b0;
      end
      if (fire_b) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/rgbyh_conv.sv]
// ----------------------------------------------------------------------------
// rgbyh_conv
// Fixed-point RGB to YUV conversion with Q0.16 weights.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbyh_conv
  import rgbyh_pkg::*;
(
  input  wire logic [7:0] chan_r,
  input  wire logic [7:0] chan_g,
  input  wire logic [7:0] chan_b,
  output logic      [7:0] y,
  output logic      [7:0] u,
  output logic      [7:0] v
);

  logic [23:0] y_sum;
  logic [24:0] u_sum;
  logic [24:0] v_sum;

  // The true sums always lie in 0 .. 2^24-1, so modular arithmetic is exact.
  always_comb begin
    y_sum = 24'(chan_r) * W_YR + 24'(chan_g) * W_YG + 24'(chan_b) * W_YB;
    u_sum = CHROMA_OFS + 25'(chan_b) * W_UB - 25'(chan_r) * W_UR - 25'(chan_g) * W_UG;
    v_sum = CHROMA_OFS + 25'(chan_r) * W_VR - 25'(chan_g) * W_VG - 25'(chan_b) * W_VB;
    y = y_sum[23:16];
    u = u_sum[23:16];
    v = v_sum[23:16];
  end

endmodule

`default_nettype wire

[sv/rgbyh_hist.sv]
// ----------------------------------------------------------------------------
// rgbyh_hist
// Luma histogram store with read-modify-write, bypass and saturating counts.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbyh_hist
  import rgbyh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hist_req_t             req,
  output logic      [COUNT_BITS-1:0] old_cnt
);

  logic [COUNT_BITS-1:0] mem [HIST_BINS];
  logic [HIST_BINS-1:0]  bin_vld;
  logic [COUNT_BITS-1:0] mem_q;
  logic                  vld_q;
  logic                  byp_q;
  logic [COUNT_BITS-1:0] byp_data;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  hit;

  always_comb begin
    if (byp_q) begin
      old_cnt = byp_data;
    end else if (vld_q) begin
      old_cnt = mem_q;
    end else begin
      old_cnt = '0;
    end
    if (req.wr_clear) begin
      wr_data = '0;
    end else if (old_cnt == COUNT_MAX) begin
      wr_data = old_cnt;
    end else begin
      wr_data = old_cnt + 1'b1;
    end
    hit = req.wr_en && (req.wr_bin == req.rd_bin);
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_bin] <= wr_data;
    end
    if (req.rd_en) begin
      mem_q    <= mem[req.rd_bin];
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld <= '0;
      vld_q   <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        bin_vld[req.wr_bin] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q <= bin_vld[req.rd_bin];
        byp_q <= hit;
      end
    end
  end

endmodule

`default_nettype wire

[sv/rgbyh_checker.sv]
// ----------------------------------------------------------------------------
// rgbyh_checker
// Port-level checks for the RGB to YUV converter with luma histogram.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbyh_checker
  import rgbyh_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic            [7:0] luma,
  input wire logic            [7:0] chroma_u,
  input wire logic            [7:0] chroma_v,
  input wire logic [COUNT_BITS-1:0] bin_count
);

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_no_stall_without_backpressure: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is not stalled");

  a_bin_beat_has_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bin_count != '0) |-> (luma == 8'd0 && chroma_u == 8'd0 && chroma_v == 8'd0))
    else $error("bin count beat carries pixel fields");

  a_stalled_output_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(luma) && $stable(chroma_u)
                                  && $stable(chroma_v) && $stable(bin_count)))
    else $error("stalled output beat changed");

endmodule

bind rgb_to_yuv_with_luma_histogram rgbyh_checker u_rgbyh_checker (.*);

`default_nettype wire

[test/tb_rgb_to_yuv_with_luma_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv_with_luma_histogram
// Self-checking testbench for the RGB to YUV converter with luma histogram.
// ----------------------------------------------------------------------------
// A directed list of pixels and bin reads is followed by random traffic that
// concentrates pixels on a few colors and reads back the bins they hit.
// Each accepted input beat is run through a local conversion and histogram
// model, and every output beat is compared in order with its prediction.
// The sender works in random bursts, and the receiver stalls in changing
// patterns, including one long hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------

module tb_rgb_to_yuv_with_luma_histogram;
  import rgbyh_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 12;
  localparam int RANDOM_BEATS = 600;
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 250;
  localparam int DRAIN_LEN   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  localparam int Y_R_WT = 19595;
  localparam int Y_G_WT = 38470;
  localparam int Y_B_WT = 7471;
  localparam int U_R_WT = -11058;
  localparam int U_G_WT = -21710;
  localparam int U_B_WT = 32768;
  localparam int V_R_WT = 32768;
  localparam int V_G_WT = -27439;
  localparam int V_B_WT = -5329;
  localparam int UV_OFFSET = 128 * 65536;

  typedef struct packed {
    logic       cmd;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] idx;
  } hist_beat_t;

  typedef struct packed {
    logic [7:0]            y;
    logic [7:0]            u;
    logic [7:0]            v;
    logic [COUNT_BITS-1:0] count;
  } yuv_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd = CMD_PIXEL;
  logic [7:0]            chan_r = 8'd0;
  logic [7:0]            chan_g = 8'd0;
  logic [7:0]            chan_b = 8'd0;
  logic [7:0]            bin_index = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            luma;
  logic [7:0]            chroma_u;
  logic [7:0]            chroma_v;
  logic [COUNT_BITS-1:0] bin_count;

  hist_beat_t            pending_beats[$];
  yuv_result_t           expected_results[$];
  logic [COUNT_BITS-1:0] luma_bins[HIST_BINS];
  hist_beat_t            offered;
  int                    burst_left = 0;
  int                    gap_left = 0;
  int                    run_cycles = 0;
  int                    cycle_count = 0;
  logic                  hold_off = 1'b0;
  int                    mismatch_count = 0;

  rgb_to_yuv_with_luma_histogram uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .chan_r    (chan_r),
    .chan_g    (chan_g),
    .chan_b    (chan_b),
    .bin_index (bin_index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .luma      (luma),
    .chroma_u  (chroma_u),
    .chroma_v  (chroma_v),
    .bin_count (bin_count)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    foreach (luma_bins[i]) luma_bins[i] = '0;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [7:0] to_byte(input int acc);
    int shifted;
    if (acc < 0) return 8'd0;
    shifted = acc >>> 16;
    if (shifted > 255) return 8'd255;
    return shifted[7:0];
  endfunction

  function automatic yuv_result_t convert_pixel(input logic [7:0] r, g, b);
    yuv_result_t res;
    res       = '0;
    res.y     = to_byte(Y_R_WT * int'(r) + Y_G_WT * int'(g) + Y_B_WT * int'(b));
    res.u     = to_byte(U_R_WT * int'(r) + U_G_WT * int'(g) + U_B_WT * int'(b)
                        + UV_OFFSET);
    res.v     = to_byte(V_R_WT * int'(r) + V_G_WT * int'(g) + V_B_WT * int'(b)
                        + UV_OFFSET);
    return res;
  endfunction

  function automatic yuv_result_t count_or_read_bin(input hist_beat_t beat);
    yuv_result_t res;
    if (beat.cmd == CMD_PIXEL) begin
      res = convert_pixel(beat.r, beat.g, beat.b);
      if (luma_bins[res.y] != COUNT_MAX) luma_bins[res.y] = luma_bins[res.y] + 1'b1;
    end else begin
      res = '0;
      res.count = luma_bins[beat.idx];
      luma_bins[beat.idx] = '0;
    end
    return res;
  endfunction

  task automatic queue_beat(input logic c, input logic [7:0] r, g, b, idx);
    hist_beat_t beat;
    beat.cmd = c;
    beat.r   = r;
    beat.g   = g;
    beat.b   = b;
    beat.idx = idx;
    pending_beats.push_back(beat);
  endtask

  task automatic report_mismatch(input string what, input yuv_result_t want,
                                 input yuv_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected y=%0d u=%0d v=%0d count=%0d, got y=%0d u=%0d v=%0d count=%0d",
               $realtime, what, want.y, want.u, want.v, want.count,
               got.y, got.u, got.v, got.count);
    end
  endtask

  always @(posedge clk) begin : drive_beats
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(count_or_read_bin(offered));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          offered = pending_beats.pop_front();
          cmd       <= offered.cmd;
          chan_r    <= offered.r;
          chan_g    <= offered.g;
          chan_b    <= offered.b;
          bin_index <= offered.idx;
          in_valid  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : long_hold_off
    if (rst) begin
      run_cycles <= 0;
      hold_off   <= 1'b0;
    end else begin
      run_cycles <= run_cycles + 1;
      hold_off   <= (run_cycles >= HOLD_START) && (run_cycles < HOLD_START + HOLD_LEN);
    end
  end

  always @(posedge clk) begin : check_results
    yuv_result_t got;
    yuv_result_t want;
    logic        stall_now;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.y     = luma;
        got.u     = chroma_u;
        got.v     = chroma_v;
        got.count = bin_count;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.y !== want.y || got.u !== want.u || got.v !== want.v ||
              got.count !== want.count) begin
            report_mismatch("mismatch", want, got);
          end
        end
      end
      case (run_cycles[8:7])
        2'd0:    stall_now = 1'b0;
        2'd1:    stall_now = ($urandom_range(0, 3) == 0);
        2'd2:    stall_now = ($urandom_range(0, 3) != 0);
        default: stall_now = (run_cycles % 3 == 0);
      endcase
      out_stall <= hold_off || stall_now;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] palette[8][3];
    logic [7:0] seen_lumas[$];
    logic [7:0] r, g, b, shade;
    int         pick;

    // Directed part: color extremes, back-to-back hits on one bin, reads
    // that return a count, a cleared bin and a bin that was never hit.
    queue_beat(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'hFF);
    queue_beat(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'h00);
    queue_beat(CMD_PIXEL, 8'd255, 8'd0, 8'd0, 8'hA5);
    queue_beat(CMD_PIXEL, 8'd0, 8'd255, 8'd0, 8'h5A);
    queue_beat(CMD_PIXEL, 8'd0, 8'd0, 8'd255, 8'h0F);
    queue_beat(CMD_PIXEL, 8'd255, 8'd255, 8'd0, 8'hF0);
    queue_beat(CMD_PIXEL, 8'd0, 8'd255, 8'd255, 8'h33);
    queue_beat(CMD_PIXEL, 8'd255, 8'd0, 8'd255, 8'hCC);
    queue_beat(CMD_PIXEL, 8'd128, 8'd128, 8'd128, 8'h00);
    queue_beat(CMD_PIXEL, 8'd128, 8'd128, 8'd128, 8'hFF);
    queue_beat(CMD_PIXEL, 8'd128, 8'd128, 8'd128, 8'h80);
    queue_beat(CMD_READ, 8'd255, 8'd255, 8'd255, 8'd0);
    queue_beat(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_beat(CMD_READ, 8'hAA, 8'h55, 8'hF0, 8'd255);
    queue_beat(CMD_READ, 8'h0F, 8'hF0, 8'h3C, convert_pixel(8'd128, 8'd128, 8'd128).y);
    queue_beat(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd17);
    queue_beat(CMD_PIXEL, 8'd1, 8'd1, 8'd1, 8'd1);
    queue_beat(CMD_PIXEL, 8'd254, 8'd254, 8'd254, 8'd254);
    queue_beat(CMD_PIXEL, 8'd1, 8'd1, 8'd1, 8'd0);
    queue_beat(CMD_READ, 8'd0, 8'd0, 8'd0, convert_pixel(8'd1, 8'd1, 8'd1).y);
    queue_beat(CMD_READ, 8'd0, 8'd0, 8'd0, convert_pixel(8'd1, 8'd1, 8'd1).y);

    foreach (palette[i]) begin
      foreach (palette[i][j]) palette[i][j] = 8'($urandom_range(0, 255));
    end
    seen_lumas.push_back(convert_pixel(8'd128, 8'd128, 8'd128).y);

    // Random part: pixels mostly from a small palette or gray levels so that
    // bins fill up, interleaved with reads that mostly target bins known to be hit.
    repeat (RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 65) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          r = palette[pick * 2][0];
          g = palette[pick * 2][1];
          b = palette[pick * 2][2];
        end else if (pick < 6) begin
          shade = 8'($urandom_range(0, 7) * 36);
          r = shade;
          g = shade;
          b = shade;
        end else begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
        seen_lumas.push_back(convert_pixel(r, g, b).y);
        if (seen_lumas.size() > 32) void'(seen_lumas.pop_front());
        queue_beat(CMD_PIXEL, r, g, b, 8'($urandom_range(0, 255)));
      end else begin
        queue_beat(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) < 7) ?
                     seen_lumas[$urandom_range(0, seen_lumas.size() - 1)] :
                     8'($urandom_range(0, 255)));
      end
    end

    while (rst) @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
